>>> hw/rtl/mdeb_pkg.sv
package mdeb_pkg;

    localparam int NUM_CHANNELS   = 8;
    localparam int FIELD_CHANNELS = 8;
    // Only as many channels as the raw-level and mask fields carry can exist.
    localparam int LIVE_CHANNELS  = (NUM_CHANNELS < FIELD_CHANNELS) ? NUM_CHANNELS
                                                                     : FIELD_CHANNELS;
    localparam int IDX_W          = (LIVE_CHANNELS > 1) ? $clog2(LIVE_CHANNELS) : 1;
    localparam int CH_W           = 3;

    localparam logic [IDX_W-1:0] LAST_CH = IDX_W'(LIVE_CHANNELS - 1);

    localparam logic [15:0] DEBOUNCE_RESET = 16'd50;
    localparam logic [7:0]  MASK_RESET     = 8'hFF;

    localparam logic REG_DEBOUNCE    = 1'b0;
    localparam logic REG_ACTIVE_MASK = 1'b1;

    localparam logic ACTION_SCAN = 1'b0;
    localparam logic ACTION_INIT = 1'b1;

    localparam logic KIND_TRIGGERED = 1'b0;
    localparam logic KIND_RELEASED  = 1'b1;

    typedef struct packed {
        logic        action;
        logic [7:0]  raw_levels;
        logic [31:0] now_time;
    } scan_item_t;

    typedef struct packed {
        logic [CH_W-1:0] sensor_index;
        logic            event_kind;
        logic            last_event;
    } evt_item_t;

    typedef struct packed {
        logic load;
        logic step;
        logic emit;
    } cmd_t;

    typedef struct packed {
        logic scan_last;
        logic pending;
        logic last_pick;
        logic out_free;
    } sts_t;

endpackage

>>> hw/rtl/mdeb_datapath.sv
module mdeb_datapath (
    input  logic                clk,
    input  logic                rst_n,
    input  mdeb_pkg::cmd_t      cmd,
    output mdeb_pkg::sts_t      sts,
    input  mdeb_pkg::scan_item_t scan_item,
    input  logic [15:0]         debounce_time,
    input  logic [7:0]          active_high_mask,
    input  logic                evt_stall,
    output logic                evt_valid,
    output mdeb_pkg::evt_item_t evt_item
);
    import mdeb_pkg::*;

    scan_item_t             item_reg;
    logic [IDX_W-1:0]       ch_reg;
    logic                   prev_reg   [LIVE_CHANNELS];
    logic                   stable_reg [LIVE_CHANNELS];
    logic [31:0]            ctime_reg  [LIVE_CHANNELS];
    logic [LIVE_CHANNELS-1:0] pend_reg;
    logic [LIVE_CHANNELS-1:0] kind_reg;
    logic                   evt_valid_reg;
    evt_item_t              evt_item_reg;

    logic                   raw;
    logic                   trig;
    logic [31:0]            diff;
    logic                   settled;
    logic [IDX_W-1:0]       pick;
    logic [LIVE_CHANNELS-1:0] rest;
    logic                   last_pick;

    always_comb
    begin
        raw     = item_reg.raw_levels[ch_reg];
        trig    = raw ^ ~active_high_mask[ch_reg];
        diff    = item_reg.now_time - ctime_reg[ch_reg];
        // The wrap-around difference counts only when it reads as non-negative.
        settled = !diff[31] && (diff >= {16'b0, debounce_time});
    end

    // Lowest pending channel goes out first; it is the last one when nothing else remains.
    always_comb
    begin
        pick = '0;
        for (int i = LIVE_CHANNELS - 1; i >= 0; i--)
        begin
            if (pend_reg[i])
            begin
                pick = IDX_W'(i);
            end
        end
        for (int i = 0; i < LIVE_CHANNELS; i++)
        begin
            rest[i] = pend_reg[i] && (IDX_W'(i) != pick);
        end
        last_pick = (rest == '0);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ch_reg        <= '0;
            pend_reg      <= '0;
            kind_reg      <= '0;
            evt_valid_reg <= 1'b0;
            for (int i = 0; i < LIVE_CHANNELS; i++)
            begin
                prev_reg[i]   <= 1'b0;
                stable_reg[i] <= 1'b0;
                ctime_reg[i]  <= '0;
            end
        end
        else
        begin
            if (cmd.load)
            begin
                ch_reg   <= '0;
                pend_reg <= '0;
            end
            if (cmd.step)
            begin
                ch_reg <= ch_reg + 1'b1;
                if (item_reg.action == ACTION_INIT)
                begin
                    prev_reg[ch_reg]   <= raw;
                    stable_reg[ch_reg] <= trig;
                    ctime_reg[ch_reg]  <= item_reg.now_time;
                end
                else if (raw != prev_reg[ch_reg])
                begin
                    prev_reg[ch_reg]  <= raw;
                    ctime_reg[ch_reg] <= item_reg.now_time;
                end
                else if (settled && (trig != stable_reg[ch_reg]))
                begin
                    stable_reg[ch_reg] <= trig;
                    pend_reg[ch_reg]   <= 1'b1;
                    kind_reg[ch_reg]   <= trig ? KIND_TRIGGERED : KIND_RELEASED;
                end
            end
            if (cmd.emit)
            begin
                pend_reg[pick] <= 1'b0;
                evt_valid_reg  <= 1'b1;
            end
            else if (!evt_stall)
            begin
                evt_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            item_reg <= scan_item;
        end
        if (cmd.emit)
        begin
            evt_item_reg.sensor_index <= CH_W'(pick);
            evt_item_reg.event_kind   <= kind_reg[pick];
            evt_item_reg.last_event   <= last_pick;
        end
    end

    assign sts.scan_last = (ch_reg == LAST_CH);
    assign sts.pending   = |pend_reg;
    assign sts.last_pick = last_pick;
    assign sts.out_free  = !evt_valid_reg || !evt_stall;

    assign evt_valid = evt_valid_reg;
    assign evt_item  = evt_item_reg;

endmodule

>>> hw/rtl/mdeb_ctrl.sv
module mdeb_ctrl (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           scan_valid,
    output logic           scan_stall,
    input  mdeb_pkg::sts_t sts,
    output mdeb_pkg::cmd_t cmd
);
    import mdeb_pkg::*;

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_SCAN = 2'd1;
    localparam logic [1:0] ST_EMIT = 2'd2;

    logic [1:0] state_reg;
    logic [1:0] state_next;

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        scan_stall = 1'b1;
        case (state_reg)
            ST_IDLE:
            begin
                scan_stall = 1'b0;
                if (scan_valid)
                begin
                    cmd.load   = 1'b1;
                    state_next = ST_SCAN;
                end
            end
            ST_SCAN:
            begin
                cmd.step = 1'b1;
                if (sts.scan_last)
                begin
                    state_next = ST_EMIT;
                end
            end
            ST_EMIT:
            begin
                if (!sts.pending)
                begin
                    state_next = ST_IDLE;
                end
                else if (sts.out_free)
                begin
                    cmd.emit = 1'b1;
                    if (sts.last_pick)
                    begin
                        state_next = ST_IDLE;
                    end
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    a_emit_needs_slot: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.emit |-> (sts.pending && sts.out_free))
        else $error("event issued without a pending channel or a free output slot");

    a_scan_to_emit: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_SCAN && sts.scan_last) |=> (state_reg == ST_EMIT))
        else $error("scan pass did not hand over to event output");

    a_emit_done: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_EMIT && !sts.pending) |=> (state_reg == ST_IDLE))
        else $error("controller stayed in event output with nothing pending");

    a_busy_after_load: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.load |=> scan_stall)
        else $error("new scan accepted while the previous one is in progress");

endmodule

>>> hw/rtl/multichannel_debounce_edge_events.sv
// Multi-channel switch debouncer with edge events.
//
// The scan channel (scan_valid, scan_stall, scan_item) takes one item per scan: an action
// bit, the raw levels of all lines and a 32-bit millisecond timestamp. An init item loads
// the stable states from the raw levels and emits nothing. A debounce scan emits one item
// on the event channel (evt_valid, evt_stall, evt_item) for every channel whose debounced
// state changed, in ascending channel order, with last_event set on the final one.
// The channels are visited one per cycle in the channel loop after the accepting edge;
// the events are then registered at the output, one per cycle while the receiver does
// not stall.
// A new scan is accepted while the last event of the previous one still waits.
// When the receiver stalls, the held event stays put and the remaining events of the scan
// wait behind it.
// Reset clears all channel state to released with zero timestamps, and restores the
// debounce time to 50 and the active-high mask to all ones. Registers sit on the APB
// port at byte addresses 0 (debounce time) and 4 (active-high mask).
module multichannel_debounce_edge_events (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 psel,
    input  logic                 penable,
    input  logic                 pwrite,
    input  logic [2:0]           paddr,
    input  logic [31:0]          pwdata,
    output logic [31:0]          prdata,
    output logic                 pready,
    input  logic                 scan_valid,
    output logic                 scan_stall,
    input  mdeb_pkg::scan_item_t scan_item,
    output logic                 evt_valid,
    input  logic                 evt_stall,
    output mdeb_pkg::evt_item_t  evt_item
);
    import mdeb_pkg::*;

    logic [15:0] debounce_reg;
    logic [7:0]  mask_reg;
    logic        reg_sel;
    logic        wr_en;
    cmd_t        cmd;
    sts_t        sts;

    assign reg_sel = paddr[2];
    assign wr_en   = psel && penable && pwrite;
    assign pready  = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            debounce_reg <= DEBOUNCE_RESET;
            mask_reg     <= MASK_RESET;
        end
        else if (wr_en)
        begin
            case (reg_sel)
                REG_DEBOUNCE:    debounce_reg <= pwdata[15:0];
                REG_ACTIVE_MASK: mask_reg     <= pwdata[7:0];
                default:         ;
            endcase
        end
    end

    always_comb
    begin
        case (reg_sel)
            REG_DEBOUNCE:    prdata = {16'b0, debounce_reg};
            REG_ACTIVE_MASK: prdata = {24'b0, mask_reg};
            default:         prdata = '0;
        endcase
    end

    mdeb_ctrl u_ctrl (
        .clk        (clk),
        .rst_n      (rst_n),
        .scan_valid (scan_valid),
        .scan_stall (scan_stall),
        .sts        (sts),
        .cmd        (cmd)
    );

    mdeb_datapath u_datapath (
        .clk              (clk),
        .rst_n            (rst_n),
        .cmd              (cmd),
        .sts              (sts),
        .scan_item        (scan_item),
        .debounce_time    (debounce_reg),
        .active_high_mask (mask_reg),
        .evt_stall        (evt_stall),
        .evt_valid        (evt_valid),
        .evt_item         (evt_item)
    );

endmodule
